@@ rtl/core/sha1_message_hasher_top_assert.svh @@
// Assertion macros for the SHA-1 message hasher.
// Depends on nothing; included by sha1_message_hasher_top, which checks its own logic.
// Expects signals named clock and reset in the including scope.
`ifndef SHA1_MESSAGE_HASHER_TOP_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SHA1MH_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define SHA1MH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sha1mh_pkg.sv @@
// Shared types and constants of the SHA-1 message hasher.
// No dependencies; imported by sha1mh_round, sha1_message_hasher_top and the bench.
package sha1mh_pkg;

   localparam logic [1:0] ACT_ABSORB  = 2'd0;
   localparam logic [1:0] ACT_DIGEST  = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam int unsigned ROUNDS = 80;
   localparam int unsigned CNT_W  = 7;

   typedef logic [4:0][31:0] chain_type;

   localparam chain_type SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                    32'hEFCDAB89, 32'h67452301};

   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
      logic [31:0] digest_word4;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic             last;
      logic [CNT_W-1:0] round;
   } rnd_status_type;

endpackage

@@ rtl/core/sha1mh_round.sv @@
// Shared SHA-1 round unit: one round per cycle, 80 rounds per block.
// Depends on sha1mh_pkg; words 0..15 come in on word_in, the rest from a 16-word window.
module sha1mh_round import sha1mh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  chain_type      h_init,
   input  logic [31:0]    word_in,
   output rnd_status_type status,
   output chain_type      sum
);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [31:0]      a_ff, b_ff, c_ff, d_ff, e_ff;
   chain_type        hb_ff;
   logic [31:0]      win_ff [16];
   logic [31:0]      sched;
   logic [31:0]      w_cur;
   logic [31:0]      f_val;
   logic [31:0]      k_val;
   logic [31:0]      t_in;

   assign sched = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign w_cur = (cnt_ff < CNT_W'(16)) ? word_in : {sched[30:0], sched[31]};

   always_comb begin
      if (cnt_ff < CNT_W'(20)) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_R0;
      end else if (cnt_ff < CNT_W'(40)) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R1;
      end else if (cnt_ff < CNT_W'(60)) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_R2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R3;
      end
   end

   assign t_in = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROUNDS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         hb_ff <= h_init;
         a_ff  <= h_init[0];
         b_ff  <= h_init[1];
         c_ff  <= h_init[2];
         d_ff  <= h_init[3];
         e_ff  <= h_init[4];
      end else if (busy_ff) begin
         a_ff <= t_in;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[15] <= w_cur;
      end
   end

   assign sum[0] = hb_ff[0] + a_ff;
   assign sum[1] = hb_ff[1] + b_ff;
   assign sum[2] = hb_ff[2] + c_ff;
   assign sum[3] = hb_ff[3] + d_ff;
   assign sum[4] = hb_ff[4] + e_ff;

   assign status.busy  = busy_ff;
   assign status.last  = busy_ff && (cnt_ff == CNT_W'(ROUNDS - 1));
   assign status.round = cnt_ff;

endmodule

@@ rtl/core/sha1_message_hasher_top.sv @@
// SHA-1 message hasher: top level with sequencer, block buffer and output register.
// Depends on sha1mh_pkg, sha1mh_round and sha1_message_hasher_top_assert.svh.
//
// Usage:
//   req channel: one beat per message byte (action absorb), or a digest or
//   restart command. rsp channel: one beat of five digest words per digest.
//   An absorb beat leaves the sequencer idle, except the 64th byte of a
//   block, which starts a compression: a setup state, the rounds through
//   the shared round unit, then a fold of the result into the chaining words.
//   A digest runs one padding block, or a second one when the bit length
//   does not fit after the 0x80 marker. No new beat is accepted while a
//   compression runs.
//   req_ready is high only while the sequencer idles.
//   Reset (synchronous) loads the initial chaining values and a zero length;
//   restart does the same at run time. A digest leaves the running state
//   intact, so absorbing may continue afterwards.
//   The rsp register holds a result until taken; new items are accepted
//   meanwhile, and a following digest waits at its end for the slot to free.
module sha1_message_hasher_top import sha1mh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "sha1_message_hasher_top_assert.svh"

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_RUN, ST_FIN} state_type;
   typedef enum logic [1:0] {PASS_DATA, PASS_PAD1, PASS_PAD2} pass_type;

   state_type      state_ff;
   pass_type       pass_ff;
   chain_type      chain_ff;
   logic [63:0]    len_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   logic [31:0]    mem [16];
   logic [31:0]    rd_ff;
   logic [3:0]     rd_addr;
   logic [31:0]    word_in;

   logic           req_fire;
   logic [5:0]     pos;
   logic           two_blk;
   logic           slot_free;
   logic           rsp_load;
   logic           rnd_start_in;
   chain_type      h_init;
   chain_type      sum;
   rnd_status_type rnd_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign pos       = len_ff[8:3];
   assign two_blk   = (pos >= 6'd56);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A finished digest moves into the output slot.
   assign rsp_load = (state_ff == ST_FIN) && (pass_ff != PASS_DATA) && slot_free &&
                     !((pass_ff == PASS_PAD1) && two_blk);

   // Second padding block chains from the first one's result, still held in the unit.
   assign rnd_start_in = (state_ff == ST_PREP);
   assign h_init       = (pass_ff == PASS_PAD2) ? sum : chain_ff;

   // Block buffer: big-endian bytes packed four to a word. Read one word ahead.
   assign rd_addr = (state_ff == ST_PREP) ? 4'd0 : (rnd_status.round[3:0] + 4'd1);

   always_ff @(posedge clock) begin
      if (req_fire && (req_data.action == ACT_ABSORB)) begin
         mem[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= req_data.data_byte;
      end
      rd_ff <= mem[rd_addr];
   end

   // Build the round word: raw data, or data with 0x80 marker, zero fill and length.
   always_comb begin
      logic [5:0] p;
      logic [7:0] mb;
      logic [7:0] lb;
      logic [7:0] ob;
      word_in = '0;
      for (int j = 0; j < 4; j++) begin
         p  = {rnd_status.round[3:0], 2'(j)};
         mb = rd_ff[{~p[1:0], 3'b000} +: 8];
         lb = len_ff[{~p[2:0], 3'b000} +: 8];
         ob = 8'h00;
         case (pass_ff)
            PASS_DATA: ob = mb;
            PASS_PAD1: begin
               if (p < pos) begin
                  ob = mb;
               end else if (p == pos) begin
                  ob = 8'h80;
               end else if (!two_blk && (p[5:3] == 3'b111)) begin
                  ob = lb;
               end
            end
            PASS_PAD2: begin
               if (p[5:3] == 3'b111) begin
                  ob = lb;
               end
            end
            default: ob = 8'h00;
         endcase
         word_in[{~p[1:0], 3'b000} +: 8] = ob;
      end
   end

   sha1mh_round u_round (
      .clock   (clock),
      .reset   (reset),
      .start   (rnd_start_in),
      .h_init  (h_init),
      .word_in (word_in),
      .status  (rnd_status),
      .sum     (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_DATA;
         chain_ff     <= SHA1_IV;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load a finished digest, or drop the held one once the receiver takes it.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_data.action)
                     ACT_ABSORB: begin
                        len_ff <= len_ff + 64'd8;
                        if (pos == 6'd63) begin
                           pass_ff  <= PASS_DATA;
                           state_ff <= ST_PREP;
                        end
                     end
                     ACT_DIGEST: begin
                        pass_ff  <= PASS_PAD1;
                        state_ff <= ST_PREP;
                     end
                     ACT_RESTART: begin
                        chain_ff <= SHA1_IV;
                        len_ff   <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_PREP: state_ff <= ST_RUN;
            ST_RUN: begin
               if (rnd_status.last) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (pass_ff == PASS_DATA) begin
                  chain_ff <= sum;
                  state_ff <= ST_IDLE;
               end else if ((pass_ff == PASS_PAD1) && two_blk) begin
                  pass_ff  <= PASS_PAD2;
                  state_ff <= ST_PREP;
               end else if (slot_free) begin
                  // Hold the digest in the unit until the output slot frees.
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.digest_word0 <= sum[0];
         rsp_data_ff.digest_word1 <= sum[1];
         rsp_data_ff.digest_word2 <= sum[2];
         rsp_data_ff.digest_word3 <= sum[3];
         rsp_data_ff.digest_word4 <= sum[4];
      end
   end

   `SHA1MH_ASSERT_IMPL(a_run_busy, state_ff == ST_RUN, rnd_status.busy, "round unit idle in run")
   `SHA1MH_ASSERT_IMPL(a_ready_idle, req_ready, !rnd_status.busy, "ready while rounds active")
   `SHA1MH_ASSERT_NEXT(a_prep_start, state_ff == ST_PREP,
                       rnd_status.busy && (rnd_status.round == '0), "round unit did not start")
   `SHA1MH_ASSERT_IMPL(a_pad2_len, (pass_ff == PASS_PAD2) && (state_ff != ST_IDLE), two_blk,
                       "second pad block not needed")
   `SHA1MH_ASSERT_IMPL(a_rsp_src, $rose(rsp_valid_ff), $past(state_ff == ST_FIN),
                       "result raised outside finish")

endmodule

@@ bench/sha1_message_hasher_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sha1_message_hasher_top: byte stream in, SHA-1 digests out.
// Depends on sha1mh_pkg and the hasher RTL; holds its own bit-exact SHA-1 predictor.
module sha1_message_hasher_top_test;
   import sha1mh_pkg::*;

   // Action code 3 has no meaning; the block must swallow it silently.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int RANDOM_BEATS = 1200;
   // Worst case is far below this: every beat a two-block digest plus long stalls.
   localparam int CYCLE_LIMIT  = 1000000;
   // The longest digest runs two padding blocks; give the tail a margin past that.
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 600;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sha1_message_hasher_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor state: chaining words, current partial block and message length in bits.
   chain_type    hash_chain  = SHA1_IV;
   logic [511:0] block_bytes = '0;
   logic [63:0]  bit_count   = '0;

   rsp_type digest_q[$];   // digests owed by the block, oldest first
   req_type stim_q[$];     // beats still to be offered

   int sent_cnt     = 0;
   int accepted_cnt = 0;
   int error_count  = 0;
   int cycle_cnt    = 0;
   int queued_beats = 0;
   int phase1_at    = 0;
   int phase2_at    = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   // One 64-byte block through the 80 rounds, folded into the chaining words.
   // Byte 0 of the block sits in bits 511:504.
   function automatic chain_type sha1_compress(input chain_type h, input logic [511:0] blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      chain_type   sum;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) begin
         t    = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
         w[i] = {t[30:0], t[31]};
      end
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int rnd = 0; rnd < 80; rnd++) begin
         if (rnd < 20) begin
            f = (b & c) | (~b & d);
            k = K_R0;
         end else if (rnd < 40) begin
            f = b ^ c ^ d;
            k = K_R1;
         end else if (rnd < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_R2;
         end else begin
            f = b ^ c ^ d;
            k = K_R3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[rnd];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      sum[0] = h[0] + a;
      sum[1] = h[1] + b;
      sum[2] = h[2] + c;
      sum[3] = h[3] + d;
      sum[4] = h[4] + e;
      return sum;
   endfunction

   // Advance the predictor by one accepted beat; queue the digest it owes, if any.
   task automatic advance_hasher(input req_type beat);
      int           pos;
      logic [511:0] pad;
      chain_type    h;
      rsp_type      owed;
      pos = int'(bit_count[8:3]);
      case (beat.action)
         ACT_ABSORB: begin
            block_bytes[511 - 8 * pos -: 8] = beat.data_byte;
            bit_count = bit_count + 64'd8;
            if (pos == 63) hash_chain = sha1_compress(hash_chain, block_bytes);
         end
         ACT_DIGEST: begin
            // Pad a copy only: keep the bytes written so far, then the 0x80 marker.
            pad = block_bytes & ~({512{1'b1}} >> (8 * pos));
            pad[511 - 8 * pos -: 8] = 8'h80;
            h = hash_chain;
            // No room left for the length: spill it into a second block.
            if (pos >= 56) begin
               h   = sha1_compress(h, pad);
               pad = '0;
            end
            pad[63:0] = bit_count;
            h = sha1_compress(h, pad);
            owed.digest_word0 = h[0];
            owed.digest_word1 = h[1];
            owed.digest_word2 = h[2];
            owed.digest_word3 = h[3];
            owed.digest_word4 = h[4];
            digest_q = {digest_q, owed};
         end
         ACT_RESTART: begin
            hash_chain  = SHA1_IV;
            block_bytes = '0;
            bit_count   = '0;
         end
         default: ;  // unused code: no state change, no digest
      endcase
   endtask

   task automatic queue_beat(input logic [1:0] act, input logic [7:0] val);
      req_type beat;
      beat.action    = act;
      beat.data_byte = val;
      stim_q = {stim_q, beat};
      // Ignored beats do not count toward the stimulus budget.
      if (act != ACT_UNUSED) queued_beats++;
   endtask

   // A message of len random bytes, with digests sprinkled in and one at the end.
   task automatic queue_message(input int len);
      for (int j = 0; j < len; j++) begin
         queue_beat(ACT_ABSORB, 8'($urandom()));
         if ($urandom_range(0, 99) < 4) queue_beat(ACT_DIGEST, 8'($urandom()));
      end
      queue_beat(ACT_DIGEST, 8'($urandom()));
   endtask

   // Run in thirds: first phase sender 38% idle / receiver 79%, then swapped, then none.
   function automatic int phase_of(input int n);
      if (n < phase1_at) return 0;
      if (n < phase2_at) return 1;
      return 2;
   endfunction

   function automatic int idle_pct(input bit sender_side, input int phase);
      case (phase)
         0:       return sender_side ? 38 : 79;
         1:       return sender_side ? 79 : 38;
         default: return 0;
      endcase
   endfunction

   task automatic check_word(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Build the whole stimulus, release reset, then wait for the block to drain.
   initial begin : stimulus
      int target;

      // Directed: empty message, extreme bytes, ignored code, back-to-back
      // digests, restart with a partial block, the "abc" vector.
      queue_beat(ACT_DIGEST,  8'h00);
      queue_beat(ACT_ABSORB,  8'h00);
      queue_beat(ACT_ABSORB,  8'hFF);
      queue_beat(ACT_DIGEST,  8'hFF);
      queue_beat(ACT_UNUSED,  8'hFF);
      queue_beat(ACT_UNUSED,  8'h00);
      queue_beat(ACT_DIGEST,  8'h00);
      queue_beat(ACT_DIGEST,  8'hAA);
      queue_beat(ACT_RESTART, 8'hFF);
      queue_beat(ACT_DIGEST,  8'h55);
      queue_beat(ACT_ABSORB,  8'h61);
      queue_beat(ACT_ABSORB,  8'h62);
      queue_beat(ACT_ABSORB,  8'h63);
      queue_beat(ACT_DIGEST,  8'h00);
      queue_beat(ACT_RESTART, 8'h00);
      queue_beat(ACT_ABSORB,  8'h80);
      queue_beat(ACT_ABSORB,  8'h7F);
      queue_beat(ACT_RESTART, 8'h5A);
      queue_beat(ACT_DIGEST,  8'hFF);

      // Random: mostly whole messages, some continuing the previous one,
      // lengths clustered around the one- and two-block padding boundaries.
      target = queued_beats + RANDOM_BEATS;
      while (queued_beats < target) begin
         if ($urandom_range(0, 99) < 60) queue_beat(ACT_RESTART, 8'($urandom()));
         case ($urandom_range(0, 9)) inside
            [0:4]: queue_message(int'($urandom_range(0, 40)));
            [5:6]: queue_message(int'(64 * $urandom_range(0, 1)
                                      + ($urandom_range(0, 1) ? 55 : 63)
                                      + $urandom_range(0, 2)));
            7: queue_message(int'($urandom_range(41, 140)));
            8: queue_message(int'($urandom_range(141, 260)));
            default: begin
               // Noise: any action code, any payload.
               repeat ($urandom_range(1, 6))
                  queue_beat(2'($urandom_range(0, 3)), 8'($urandom()));
            end
         endcase
      end
      phase1_at = stim_q.size() / 3;
      phase2_at = 2 * stim_q.size() / 3;

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (stim_q.size() != 0 || sent_cnt != accepted_cnt || digest_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && digest_q.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // Driver: offer a new beat only once the last one was taken; hold it until then.
   // At each phase boundary, pause until every owed digest has come back.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (sent_cnt == accepted_cnt) begin
         if (stim_q.size() == 0
             || ((sent_cnt == phase1_at || sent_cnt == phase2_at) && digest_q.size() != 0)
             || $urandom_range(0, 99) < idle_pct(1'b1, phase_of(sent_cnt))) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= stim_q.pop_front();
            sent_cnt  <= sent_cnt + 1;
         end
      end
   end

   // Predict at the accepting edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         advance_hasher(req_data);
         accepted_cnt <= accepted_cnt + 1;
      end
   end

   // Receiver pacing. Early in the last phase, hold ready low for a long stretch
   // while the sender keeps going, so the result slot fills and req_ready drops.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && accepted_cnt >= phase2_at + 10) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0, phase_of(accepted_cnt)));
         end
      end
   end

   // Monitor: each digest beat against the oldest owed digest, word by word.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest beat, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = digest_q.pop_front();
            check_word("digest_word0", want.digest_word0, rsp_data.digest_word0);
            check_word("digest_word1", want.digest_word1, rsp_data.digest_word1);
            check_word("digest_word2", want.digest_word2, rsp_data.digest_word2);
            check_word("digest_word3", want.digest_word3, rsp_data.digest_word3);
            check_word("digest_word4", want.digest_word4, rsp_data.digest_word4);
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sha1mh_pkg.sv
rtl/core/sha1mh_round.sv
rtl/core/sha1_message_hasher_top.sv
bench/sha1_message_hasher_top_test.sv
